/* sv/fraction_arith_reduce_top_defines.svh */
// Assertion macros for the fraction reduce block.
`ifndef FRACTION_ARITH_REDUCE_TOP_DEFINES_SVH
`define FRACTION_ARITH_REDUCE_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define FAR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FAR_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FAR_ASSERT(label, clk, rst_n, prop, msg)
`define FAR_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

/* sv/far_pkg.sv */
package far_pkg;
    localparam int OperandWidth = 16;
    localparam int OutWidth     = 33;
    localparam int ProdWidth    = 2 * OperandWidth;
    // magnitude of a sum of two products
    localparam int MagWidth     = ProdWidth + 1;
    localparam int CntWidth     = $clog2(MagWidth + 1);

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    typedef struct packed {
        logic                neg;
        logic [MagWidth-1:0] mag;
    } smag_t;

    // classified word passed from front to back
    typedef struct packed {
        cmd_t                   cmd;
        logic                   neg_a;
        logic                   neg_b;
        logic [ProdWidth-1:0]   a;
        logic [ProdWidth-1:0]   b;
        logic                   neg_c;
        logic                   neg_d;
        logic [ProdWidth-1:0]   c;
        logic [ProdWidth-1:0]   d;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_GCD,
        ST_QNUM,
        ST_QDEN,
        ST_DONE
    } st_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;
endpackage

/* sv/fraction_arith_reduce_top.sv */
// Exact fraction arithmetic with gcd reduction. An item (command and two
// signed 16-bit fractions) is taken into a two-word queue; the back end forms
// the cross products with one shared 32x32 multiplier, then runs Euclid's
// loop on a serial divider and divides both parts by the gcd on the same
// divider. One finished word is held at the output while the next is worked.
module fraction_arith_reduce_top (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    push,
    output logic                                    full,
    input  logic [1:0]                              command,
    input  logic signed [far_pkg::OperandWidth-1:0] first_num,
    input  logic signed [far_pkg::OperandWidth-1:0] first_den,
    input  logic signed [far_pkg::OperandWidth-1:0] second_num,
    input  logic signed [far_pkg::OperandWidth-1:0] second_den,
    output logic                                    empty,
    input  logic                                    pop,
    output logic signed [far_pkg::OutWidth-1:0]     result_num,
    output logic signed [far_pkg::OutWidth-1:0]     result_den,
    output logic                                    fault
);
    far_pkg::job_t job;
    logic          job_valid, job_take, res_valid;

    far_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .command(command), .first_num(first_num), .first_den(first_den),
        .second_num(second_num), .second_den(second_den),
        .job_valid(job_valid), .job_take(job_take), .job(job)
    );

    far_back u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job_take(job_take),
        .job(job), .res_valid(res_valid), .res_take(pop && res_valid),
        .res_num(result_num), .res_den(result_den), .res_fault(fault)
    );

    assign empty = !res_valid;
endmodule

/* sv/far_front.sv */
module far_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [1:0]                           command,
    input  logic signed [far_pkg::OperandWidth-1:0] first_num,
    input  logic signed [far_pkg::OperandWidth-1:0] first_den,
    input  logic signed [far_pkg::OperandWidth-1:0] second_num,
    input  logic signed [far_pkg::OperandWidth-1:0] second_den,
    output logic                                 job_valid,
    input  logic                                 job_take,
    output far_pkg::job_t                        job
);
    localparam int W = far_pkg::OperandWidth;
    localparam int P = far_pkg::ProdWidth;

    // two-entry queue between front and back
    far_pkg::job_t q_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    cnt_reg;
    far_pkg::job_t jin;
    logic [W-1:0]  m1n, m1d, m2n, m2d;
    logic          accept;

    function automatic logic [W-1:0] magof(input logic [W-1:0] v);
        magof = v[W-1] ? (~v + 1'b1) : v;
    endfunction

    always_comb
    begin
        m1n = magof(first_num);
        m1d = magof(first_den);
        m2n = magof(second_num);
        m2d = magof(second_den);
        jin.cmd = far_pkg::cmd_t'(command);
        // pair operands for the products each command needs
        case (far_pkg::cmd_t'(command))
            far_pkg::CMD_ADD, far_pkg::CMD_SUB:
            begin
                jin.a = {{W{1'b0}}, m1d}; jin.neg_a = first_den[W-1];
                jin.b = {{W{1'b0}}, m2n}; jin.neg_b = second_num[W-1];
                jin.c = {{W{1'b0}}, m2d}; jin.neg_c = second_den[W-1];
                jin.d = {{W{1'b0}}, m1n}; jin.neg_d = first_num[W-1];
            end
            far_pkg::CMD_MUL:
            begin
                jin.a = {{W{1'b0}}, m1n}; jin.neg_a = first_num[W-1];
                jin.b = {{W{1'b0}}, m2n}; jin.neg_b = second_num[W-1];
                jin.c = {{W{1'b0}}, m1d}; jin.neg_c = first_den[W-1];
                jin.d = {{W{1'b0}}, m2d}; jin.neg_d = second_den[W-1];
            end
            default:
            begin
                jin.a = {{W{1'b0}}, m1n}; jin.neg_a = first_num[W-1];
                jin.b = {{W{1'b0}}, m2d}; jin.neg_b = second_den[W-1];
                jin.c = {{W{1'b0}}, m1d}; jin.neg_c = first_den[W-1];
                jin.d = {{W{1'b0}}, m2n}; jin.neg_d = second_num[W-1];
            end
        endcase
    end

    assign full      = cnt_reg == 2'd2;
    assign accept    = push && !full;
    assign job_valid = cnt_reg != 2'd0;
    assign job       = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[wr_ptr_reg] <= jin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (accept)
                wr_ptr_reg <= !wr_ptr_reg;
            if (job_take && job_valid)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(accept) - 2'(job_take && job_valid);
        end
    end
endmodule

/* sv/far_div.sv */
module far_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [far_pkg::MagWidth-1:0]       dividend,
    input  logic [far_pkg::MagWidth-1:0]       divisor,
    output far_pkg::div_ctl_t                  ctl,
    output logic [far_pkg::MagWidth-1:0]       quotient,
    output logic [far_pkg::MagWidth-1:0]       remainder
);
    `include "fraction_arith_reduce_top_defines.svh"
    localparam int M = far_pkg::MagWidth;
    localparam int C = far_pkg::CntWidth;

    logic [M-1:0] q_reg, r_reg, d_reg;
    logic [C-1:0] cnt_reg;
    logic         busy_reg, done_reg;
    logic [M:0]   trial;
    logic [M-1:0] rsh;

    // restoring division, one quotient bit per cycle
    assign rsh   = {r_reg[M-2:0], q_reg[M-1]};
    assign trial = {1'b0, rsh} - {1'b0, d_reg};

    assign quotient  = q_reg;
    assign remainder = r_reg;
    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[M] && !r_reg[M-1])
            begin
                r_reg <= trial[M-1:0];
                q_reg <= {q_reg[M-2:0], 1'b1};
            end
            else if (r_reg[M-1])
            begin
                r_reg <= rsh - d_reg;
                q_reg <= {q_reg[M-2:0], 1'b1};
            end
            else
            begin
                r_reg <= rsh;
                q_reg <= {q_reg[M-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= C'(M);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == C'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    `FAR_ASSERT(a_div_done_after_busy, clk, rst_n, ctl.done |-> $past(busy_reg), "done without busy")
    `FAR_ASSERT(a_div_no_start_busy, clk, rst_n, busy_reg |-> !start, "start while busy")
    `FAR_ASSERT(a_div_done_pulse, clk, rst_n, ctl.done |=> !ctl.done, "done held")
endmodule

/* sv/far_back.sv */
module far_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                job_valid,
    output logic                                job_take,
    input  far_pkg::job_t                       job,
    output logic                                res_valid,
    input  logic                                res_take,
    output logic signed [far_pkg::OutWidth-1:0] res_num,
    output logic signed [far_pkg::OutWidth-1:0] res_den,
    output logic                                res_fault
);
    `include "fraction_arith_reduce_top_defines.svh"
    localparam int M = far_pkg::MagWidth;
    localparam int O = far_pkg::OutWidth;
    localparam int P = far_pkg::ProdWidth;

    far_pkg::st_t      st_reg, st_next;
    logic [1:0]        step_reg;
    logic [P-1:0]      pa_reg, pb_reg;
    logic              na_reg, nb_reg;
    far_pkg::smag_t    num_reg, den_reg, ga_reg, gb_reg;
    logic [M-1:0]      qn_reg;
    logic              out_full_reg;
    logic signed [O-1:0] on_reg, od_reg;
    logic              of_reg;
    logic              div_start;
    logic [M-1:0]      div_a, div_b, div_q, div_r;
    far_pkg::div_ctl_t dctl;
    logic [M-1:0]      prod;
    far_pkg::smag_t    sum;
    logic              neg_p;
    // divider launches for the two quotients
    logic              qnum_go_reg;
    logic              qden_go_reg;

    far_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(div_a), .divisor(div_b),
        .ctl(dctl), .quotient(div_q), .remainder(div_r)
    );

    function automatic logic [O-1:0] to_out(input logic neg, input logic [M-1:0] mag);
        logic [O-1:0] m;
        m = O'(mag);
        to_out = neg ? (~m + 1'b1) : m;
    endfunction

    // one multiplier, used for the two or three products over successive cycles
    always_comb
    begin
        prod  = M'(pa_reg * pb_reg);
        neg_p = (prod != '0) && (na_reg != nb_reg);
        // subtract: negate first_den * second_num
        if (job.cmd == far_pkg::CMD_SUB && step_reg == 2'd0)
            neg_p = (prod != '0) && !(na_reg != nb_reg);
        if (num_reg.neg == neg_p)
            sum = '{neg: num_reg.neg, mag: num_reg.mag + prod};
        else if (num_reg.mag >= prod)
            sum = '{neg: num_reg.neg && (num_reg.mag != prod), mag: num_reg.mag - prod};
        else
            sum = '{neg: neg_p, mag: prod - num_reg.mag};
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            far_pkg::ST_IDLE: if (job_valid) st_next = far_pkg::ST_PROD;
            far_pkg::ST_PROD: if (step_reg == 2'd2) st_next = far_pkg::ST_GCD;
            far_pkg::ST_GCD:
                if (gb_reg.mag == '0 && !dctl.busy && !dctl.start)
                    st_next = (ga_reg.mag == '0) ? far_pkg::ST_DONE : far_pkg::ST_QNUM;
            far_pkg::ST_QNUM: if (dctl.done) st_next = far_pkg::ST_QDEN;
            far_pkg::ST_QDEN: if (dctl.done) st_next = far_pkg::ST_DONE;
            far_pkg::ST_DONE: if (!out_full_reg) st_next = far_pkg::ST_IDLE;
            default: st_next = far_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        job_take  = st_reg == far_pkg::ST_DONE && !out_full_reg;
        div_start = 1'b0;
        div_a     = ga_reg.mag;
        div_b     = gb_reg.mag;
        case (st_reg)
            far_pkg::ST_GCD:
                div_start = gb_reg.mag != '0 && !dctl.busy && !dctl.done;
            far_pkg::ST_QNUM:
            begin
                div_a = num_reg.mag;
                div_b = ga_reg.mag;
                div_start = qnum_go_reg;
            end
            far_pkg::ST_QDEN:
            begin
                div_a = den_reg.mag;
                div_b = ga_reg.mag;
                div_start = qden_go_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            far_pkg::ST_IDLE:
            begin
                pa_reg <= job.a; pb_reg <= job.b;
                na_reg <= job.neg_a; nb_reg <= job.neg_b;
                num_reg <= '0;
                step_reg <= 2'd0;
            end
            far_pkg::ST_PROD:
            begin
                if (step_reg == 2'd0)
                begin
                    num_reg <= '{neg: neg_p, mag: prod};
                    pa_reg <= job.c; pb_reg <= job.d;
                    na_reg <= job.neg_c; nb_reg <= job.neg_d;
                    // multiply and divide need a single numerator product
                    if (job.cmd == far_pkg::CMD_MUL || job.cmd == far_pkg::CMD_DIV)
                        step_reg <= 2'd2;
                    else
                        step_reg <= 2'd1;
                end
                else if (step_reg == 2'd1)
                begin
                    step_reg <= 2'd2;
                    num_reg <= sum;
                    // denominator is first_den * second_den for add/sub
                    pa_reg <= job.a; pb_reg <= job.c;
                    na_reg <= job.neg_a; nb_reg <= job.neg_c;
                end
                else
                begin
                    den_reg <= '{neg: neg_p, mag: prod};
                    ga_reg <= num_reg;
                    gb_reg <= '{neg: neg_p, mag: prod};
                end
            end
            far_pkg::ST_GCD:
                if (dctl.done)
                begin
                    ga_reg <= gb_reg;
                    gb_reg <= '{neg: ga_reg.neg && (div_r != '0), mag: div_r};
                end
            far_pkg::ST_QNUM:
                if (dctl.done) qn_reg <= div_q;
            default: ;
        endcase
        if (st_reg == far_pkg::ST_DONE && !out_full_reg)
        begin
            if (ga_reg.mag == '0)
            begin
                on_reg <= '0; od_reg <= '0; of_reg <= 1'b1;
            end
            else
            begin
                on_reg <= to_out((qn_reg != '0) && (num_reg.neg != ga_reg.neg), qn_reg);
                od_reg <= to_out((div_q != '0) && (den_reg.neg != ga_reg.neg), div_q);
                of_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= far_pkg::ST_IDLE;
            out_full_reg <= 1'b0;
            qnum_go_reg  <= 1'b0;
            qden_go_reg  <= 1'b0;
        end
        else
        begin
            st_reg      <= st_next;
            qnum_go_reg <= st_reg == far_pkg::ST_GCD && st_next == far_pkg::ST_QNUM;
            qden_go_reg <= st_reg == far_pkg::ST_QNUM && dctl.done;
            if (job_take)
                out_full_reg <= 1'b1;
            else if (res_take)
                out_full_reg <= 1'b0;
        end
    end

    assign res_valid = out_full_reg;
    assign res_num   = on_reg;
    assign res_den   = od_reg;
    assign res_fault = of_reg;

    `FAR_ASSERT(a_take_only_done, clk, rst_n, job_take |-> st_reg == far_pkg::ST_DONE, "take outside done")
    `FAR_ASSERT(a_take_has_job, clk, rst_n, job_take |-> job_valid, "take with empty queue")
    `FAR_ASSERT(a_take_sets_out, clk, rst_n, job_take |=> out_full_reg, "result not held")
endmodule

/* bench/fraction_arith_reduce_top_tb.sv */
module fraction_arith_reduce_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = far_pkg::OperandWidth;
    localparam int OW = far_pkg::OutWidth;
    localparam int CycleLimit = 4000000;

    typedef struct {
        logic [OW-1:0] num;
        logic [OW-1:0] den;
        logic          flt;
    } frac_res_t;

    typedef struct {
        far_pkg::cmd_t  cmd;
        logic [W-1:0]   n1;
        logic [W-1:0]   d1;
        logic [W-1:0]   n2;
        logic [W-1:0]   d2;
        bit             known;
        frac_res_t      res;
    } frac_row_t;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    logic [1:0] command;
    logic signed [W-1:0] first_num;
    logic signed [W-1:0] first_den;
    logic signed [W-1:0] second_num;
    logic signed [W-1:0] second_den;
    logic empty;
    logic pop;
    logic signed [OW-1:0] result_num;
    logic signed [OW-1:0] result_den;
    logic fault;

    frac_res_t reduced_q[$];
    int errors = 0;
    int sent = 0;
    int got = 0;
    int faults_seen = 0;
    longint cycles = 0;
    bit hold_off = 0;
    bit quiet = 0;
    bit sent_all = 0;
    bit [3:0] cmd_seen = '0;

    fraction_arith_reduce_top i_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .command(command),
        .first_num(first_num), .first_den(first_den), .second_num(second_num),
        .second_den(second_den), .empty(empty), .pop(pop),
        .result_num(result_num), .result_den(result_den), .fault(fault)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Euclid on signed 64-bit values; SV % truncates toward zero like C.
    function automatic frac_res_t reduce_fraction(far_pkg::cmd_t cmd, logic [W-1:0] n1,
        logic [W-1:0] d1, logic [W-1:0] n2, logic [W-1:0] d2);
        longint a, b, c, d, num, den, x, y, r;
        frac_res_t res;
        a = longint'($signed(n1));
        b = longint'($signed(d1));
        c = longint'($signed(n2));
        d = longint'($signed(d2));
        case (cmd)
            far_pkg::CMD_ADD: begin num = b * c + d * a; den = b * d; end
            far_pkg::CMD_SUB: begin num = d * a - b * c; den = b * d; end
            far_pkg::CMD_MUL: begin num = a * c; den = b * d; end
            default: begin num = a * d; den = b * c; end
        endcase
        x = num;
        y = den;
        while (y != 0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        if (x == 0)
        begin
            res.num = '0;
            res.den = '0;
            res.flt = 1'b1;
        end
        else
        begin
            res.num = OW'(num / x);
            res.den = OW'(den / x);
            res.flt = 1'b0;
        end
        return res;
    endfunction

    task automatic send_word(far_pkg::cmd_t cmd, logic [W-1:0] n1, logic [W-1:0] d1,
        logic [W-1:0] n2, logic [W-1:0] d2);
        if (!quiet)
        begin
            while ($urandom_range(99) < 18)
            begin
                push <= 1'b0;
                @(posedge clk);
            end
        end
        push <= 1'b1;
        command <= cmd;
        first_num <= n1;
        first_den <= d1;
        second_num <= n2;
        second_den <= d2;
        @(posedge clk);
        while (full)
            @(posedge clk);
        reduced_q.push_back(reduce_fraction(cmd, n1, d1, n2, d2));
        cmd_seen[cmd] = 1'b1;
        sent++;
    endtask

    function automatic logic [W-1:0] rand_operand();
        case ($urandom_range(9))
            0: return '0;
            1: return {1'b1, {(W-1){1'b0}}};
            2: return {1'b0, {(W-1){1'b1}}};
            3, 4: return W'($signed($urandom_range(40)) - 20);
            5, 6: return W'($urandom_range(255));
            default: return W'($urandom);
        endcase
    endfunction

    // Drain side: random stalls, plus one long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                frac_res_t e;
                if (reduced_q.size() == 0)
                begin
                    $error("unexpected result word num=%0d den=%0d", result_num, result_den);
                    errors++;
                end
                else
                begin
                    e = reduced_q.pop_front();
                    if (result_num !== e.num)
                    begin
                        $error("result_num expected %0d actual %0d",
                            $signed(e.num), result_num);
                        errors++;
                    end
                    if (result_den !== e.den)
                    begin
                        $error("result_den expected %0d actual %0d",
                            $signed(e.den), result_den);
                        errors++;
                    end
                    if (fault !== e.flt)
                    begin
                        $error("fault expected %0b actual %0b", e.flt, fault);
                        errors++;
                    end
                    if (fault === 1'b1)
                        faults_seen++;
                end
                got++;
            end
            pop <= !hold_off && (quiet || $urandom_range(99) >= 18);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("fraction_arith_reduce_top test failed");
            $finish;
        end
    end

    initial
    begin
        frac_row_t rows[$];
        frac_row_t row;
        frac_res_t zero_fault;
        logic [W-1:0] mn, mx;
        int tail;
        zero_fault.num = '0;
        zero_fault.den = '0;
        zero_fault.flt = 1'b1;
        mn = {1'b1, {(W-1){1'b0}}};
        mx = {1'b0, {(W-1){1'b1}}};
        push = 1'b0;
        command = far_pkg::CMD_ADD;
        first_num = '0;
        first_den = '0;
        second_num = '0;
        second_den = '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: known = typed-in expectation, else from the predictor.
        rows = '{
            '{far_pkg::CMD_ADD, 16'd1, 16'd2, 16'd1, 16'd3, 1'b0, zero_fault},
            '{far_pkg::CMD_SUB, 16'd1, 16'd2, 16'd1, 16'd2, 1'b0, zero_fault},
            '{far_pkg::CMD_MUL, 16'd0, 16'd0, 16'd5, 16'd7, 1'b1, zero_fault},
            '{far_pkg::CMD_DIV, 16'd0, 16'd3, 16'd0, 16'd5, 1'b1, zero_fault},
            '{far_pkg::CMD_ADD, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, zero_fault},
            '{far_pkg::CMD_MUL, 16'd3, 16'd0, 16'd2, 16'd5, 1'b1, '{33'd1, 33'd0, 1'b0}},
            '{far_pkg::CMD_DIV, 16'd3, 16'd4, 16'd0, 16'd5, 1'b1, '{33'd1, 33'd0, 1'b0}},
            '{far_pkg::CMD_MUL, 16'd2, 16'd3, 16'd3, 16'd2, 1'b1, '{33'd1, 33'd1, 1'b0}},
            '{far_pkg::CMD_MUL, -16'sd1, 16'd2, 16'd1, 16'd3, 1'b0, zero_fault},
            '{far_pkg::CMD_MUL, 16'd1, -16'sd2, 16'd1, 16'd3, 1'b0, zero_fault},
            '{far_pkg::CMD_ADD, mn, mn, mn, mn, 1'b0, zero_fault},
            '{far_pkg::CMD_SUB, mn, mx, mx, mn, 1'b0, zero_fault},
            '{far_pkg::CMD_MUL, mn, 16'd1, mn, 16'd1, 1'b0, zero_fault},
            '{far_pkg::CMD_DIV, mn, 16'd1, 16'd1, mn, 1'b0, zero_fault},
            '{far_pkg::CMD_ADD, mx, 16'd1, mx, 16'd1, 1'b0, zero_fault},
            '{far_pkg::CMD_ADD, mn, 16'd1, mn, 16'd1, 1'b0, zero_fault},
            '{far_pkg::CMD_SUB, mx, 16'hffff, mx, 16'd1, 1'b0, zero_fault},
            '{far_pkg::CMD_DIV, mx, mn, mn, mx, 1'b0, zero_fault},
            '{far_pkg::CMD_MUL, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b0, zero_fault},
            '{far_pkg::CMD_ADD, 16'd28657, 16'd17711, 16'd0, 16'd1, 1'b0, zero_fault},
            '{far_pkg::CMD_SUB, 16'd5, -16'sd7, -16'sd3, 16'd11, 1'b0, zero_fault},
            '{far_pkg::CMD_DIV, -16'sd6, 16'd4, 16'd9, -16'sd2, 1'b0, zero_fault}
        };
        foreach (rows[i])
        begin
            row = rows[i];
            send_word(row.cmd, row.n1, row.d1, row.n2, row.d2);
            if (row.known)
                reduced_q[$] = row.res;
        end

        // Long receiver hold-off while the sender keeps offering words.
        hold_off = 1'b1;
        fork
            begin
                repeat (6000) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int k = 0; k < 8; k++)
                send_word(far_pkg::cmd_t'($urandom_range(3)), rand_operand(),
                    rand_operand(), rand_operand(), rand_operand());
        join
        push <= 1'b0;
        while (reduced_q.size() != 0)
            @(posedge clk);

        for (int k = 0; k < 340; k++)
        begin
            quiet = (k >= 100 && k < 160);
            send_word(far_pkg::cmd_t'($urandom_range(3)), rand_operand(),
                rand_operand(), rand_operand(), rand_operand());
        end
        quiet = 0;
        push <= 1'b0;
        sent_all = 1;

        while (reduced_q.size() != 0)
            @(posedge clk);
        tail = 0;
        while (tail < 2000)
        begin
            @(posedge clk);
            tail++;
        end

        $display("Reduced %0d fraction words (%0d flagged 0/0), commands hit mask %b.",
            got, faults_seen, cmd_seen);
        if (errors == 0 && reduced_q.size() == 0)
            $display("fraction_arith_reduce_top test passed");
        else
            $display("fraction_arith_reduce_top test failed");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+sv
sv/far_pkg.sv
sv/far_front.sv
sv/far_div.sv
sv/far_back.sv
sv/fraction_arith_reduce_top.sv
bench/fraction_arith_reduce_top_tb.sv
